@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/ihex_pkg.sv @@
package ihex_pkg;

    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_UA    = 8'h41;
    localparam logic [7:0] CHR_UF    = 8'h46;
    localparam logic [7:0] CHR_LA    = 8'h61;
    localparam logic [7:0] CHR_LF    = 8'h66;
    localparam logic [3:0] DIGIT_TEN = 4'd10;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_CHECKSUM = 2'd0;
    localparam logic [1:0] ERR_TYPE     = 2'd1;
    localparam logic [1:0] ERR_DIGIT    = 2'd2;
    localparam logic [1:0] ERR_TRUNC    = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [1:0]  error_code;
    } t_out_word;

    typedef struct packed {
        logic       ok;
        logic       colon;
        logic [3:0] value;
    } t_digit;

endpackage

@@ sv/intel_hex_record_loader.sv @@
// path: a character accepted into the input register is parsed from there, and its word
// is registered in the result register that drives o_out_word
// throughput: one character per cycle while the output is not stalled
// a stalled output word holds the parser; the input register then stalls too
// reset: synchronous active-low i_rst_n clears both stage valids and the parser
// state (hunting for colon, not stopped); no clearing pass
module intel_hex_record_loader (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ihex_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ihex_pkg::t_out_word o_out_word
);

    // input register stage
    logic                r_in_valid;
    ihex_pkg::t_in_word  r_in_word;

    // result register stage
    logic                r_out_valid;
    ihex_pkg::t_out_word r_out_word;

    logic                w_fire;
    logic                w_res_valid;
    ihex_pkg::t_out_word w_res;

    // parse a character when the result register can take whatever it makes
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    // input register refills whenever its word moves on or it is empty
    assign o_in_stall = r_in_valid && !w_fire;

    ihex_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_word      (r_in_word),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            // load a fresh result if one came, else drop the delivered word
            if (w_fire && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        // payload registers, no reset
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_fire && w_res_valid) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ sv/ihex_digit.sv @@
// ascii hex digit decode
module ihex_digit (
    input  logic [7:0]      i_char,
    output ihex_pkg::t_digit o_digit
);

    logic [7:0] w_num;
    logic [7:0] w_upper;
    logic [7:0] w_lower;

    assign w_num   = i_char - ihex_pkg::CHR_ZERO;
    assign w_upper = i_char - ihex_pkg::CHR_UA;
    assign w_lower = i_char - ihex_pkg::CHR_LA;

    always_comb begin
        o_digit.colon = (i_char == ihex_pkg::CHR_COLON);
        o_digit.ok    = 1'b0;
        o_digit.value = '0;
        priority if (i_char >= ihex_pkg::CHR_ZERO && i_char <= ihex_pkg::CHR_NINE) begin
            o_digit.ok    = 1'b1;
            o_digit.value = w_num[3:0];
        end else if (i_char >= ihex_pkg::CHR_UA && i_char <= ihex_pkg::CHR_UF) begin
            o_digit.ok    = 1'b1;
            o_digit.value = w_upper[3:0] + ihex_pkg::DIGIT_TEN;
        end else if (i_char >= ihex_pkg::CHR_LA && i_char <= ihex_pkg::CHR_LF) begin
            o_digit.ok    = 1'b1;
            o_digit.value = w_lower[3:0] + ihex_pkg::DIGIT_TEN;
        end else begin
            // not a hex digit
            o_digit.ok    = 1'b0;
        end
    end

endmodule

@@ sv/ihex_step.sv @@
// record parser state and per-character update
module ihex_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ihex_pkg::t_in_word  i_word,
    output logic                o_res_valid,
    output ihex_pkg::t_out_word o_res
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_CHECK
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_low_next, n_low_next;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_left, n_left;
    logic [15:0] r_addr, n_addr;
    logic        r_type, n_type;
    logic [7:0]  r_sum, n_sum;
    logic        r_stopped, n_stopped;

    ihex_pkg::t_digit w_dig;
    logic [7:0]       w_byte;
    logic [7:0]       w_sum_b;

    ihex_digit u_digit (
        .i_char  (i_word.char_code),
        .o_digit (w_dig)
    );

    assign w_byte  = {r_high, w_dig.value};
    assign w_sum_b = r_sum + w_byte;

    always_comb begin
        n_phase     = r_phase;
        n_low_next  = r_low_next;
        n_high      = r_high;
        n_left      = r_left;
        n_addr      = r_addr;
        n_type      = r_type;
        n_sum       = r_sum;
        n_stopped   = r_stopped;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_fire && !r_stopped) begin
            if (r_phase == PH_HUNT) begin
                if (!i_word.end_of_stream && w_dig.colon) begin
                    n_phase    = PH_COUNT;
                    n_low_next = 1'b0;
                    n_high     = '0;
                    n_sum      = '0;
                end
            end else if (i_word.end_of_stream) begin
                n_stopped        = 1'b1;
                o_res_valid      = 1'b1;
                o_res.kind       = ihex_pkg::KIND_ERROR;
                o_res.error_code = ihex_pkg::ERR_TRUNC;
            end else if (!w_dig.ok) begin
                n_stopped        = 1'b1;
                o_res_valid      = 1'b1;
                o_res.kind       = ihex_pkg::KIND_ERROR;
                o_res.error_code = ihex_pkg::ERR_DIGIT;
            end else if (!r_low_next) begin
                n_high     = w_dig.value;
                n_low_next = 1'b1;
            end else begin
                n_low_next = 1'b0;
                n_sum      = w_sum_b;
                unique case (r_phase)
                    PH_COUNT: begin
                        n_left  = w_byte;
                        n_phase = PH_ADDR_HI;
                    end
                    PH_ADDR_HI: begin
                        n_addr  = {w_byte, 8'h00};
                        n_phase = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        n_addr  = {r_addr[15:8], w_byte};
                        n_phase = PH_TYPE;
                    end
                    PH_TYPE: begin
                        if (w_byte > 8'd1) begin
                            n_stopped        = 1'b1;
                            o_res_valid      = 1'b1;
                            o_res.kind       = ihex_pkg::KIND_ERROR;
                            o_res.error_code = ihex_pkg::ERR_TYPE;
                        end else begin
                            n_type  = w_byte[0];
                            n_phase = (r_left == 8'd0) ? PH_CHECK : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (!r_type) begin
                            o_res_valid     = 1'b1;
                            o_res.kind      = ihex_pkg::KIND_WRITE;
                            o_res.address   = r_addr;
                            o_res.data_byte = w_byte;
                            n_addr          = r_addr + 16'd1;
                        end
                        n_left = r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        if (w_sum_b != 8'd0) begin
                            n_stopped        = 1'b1;
                            o_res_valid      = 1'b1;
                            o_res.kind       = ihex_pkg::KIND_ERROR;
                            o_res.error_code = ihex_pkg::ERR_CHECKSUM;
                        end else begin
                            n_phase = PH_HUNT;
                            if (r_type) begin
                                n_stopped   = 1'b1;
                                o_res_valid = 1'b1;
                                o_res.kind  = ihex_pkg::KIND_DONE;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_low_next <= 1'b0;
            r_high     <= '0;
            r_left     <= '0;
            r_addr     <= '0;
            r_type     <= 1'b0;
            r_sum      <= '0;
            r_stopped  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_low_next <= n_low_next;
            r_high     <= n_high;
            r_left     <= n_left;
            r_addr     <= n_addr;
            r_type     <= n_type;
            r_sum      <= n_sum;
            r_stopped  <= n_stopped;
        end
    end

endmodule

@@ sv/ihex_checker.sv @@
`include "assert_macros.svh"

module ihex_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ihex_pkg::t_out_word o_out_word
);

    logic r_ended;

    // a completion or error word has been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
        end else if (o_out_valid && !i_out_stall &&
                     o_out_word.kind != ihex_pkg::KIND_WRITE) begin
            r_ended <= 1'b1;
        end
    end

    `ASSERT_CLK(a_out_hold,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word),
        "stalled output word changed")
    `ASSERT_CLK(a_no_word_after_end, r_ended |-> !o_out_valid,
        "output word after completion or error")
    `ASSERT_CLK(a_kind_legal, o_out_valid |-> o_out_word.kind <= ihex_pkg::KIND_ERROR,
        "illegal result kind")
    `ASSERT_CLK(a_nonwrite_zero,
        o_out_valid && o_out_word.kind != ihex_pkg::KIND_WRITE |->
            o_out_word.address == 16'd0 && o_out_word.data_byte == 8'd0,
        "nonzero payload on non-write word")
    `ASSERT_ALWAYS(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall,
        "input stalled without output back-pressure")

endmodule

bind intel_hex_record_loader ihex_checker u_ihex_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

@@ test/intel_hex_record_loader_tb.sv @@
module intel_hex_record_loader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    // record types the loader knows
    localparam logic [7:0] REC_DATA  = 8'h00;
    localparam logic [7:0] REC_EOF   = 8'h01;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_WORDS = 1000;
    localparam int unsigned BURST_CYCLES = 300;

    // parser phases, tracked by the predictor
    typedef enum logic [2:0] {
        P_HUNT, P_COUNT, P_ADDR_HI, P_ADDR_LO, P_TYPE, P_DATA, P_CHECK
    } t_ld_phase;

    // how the single load session is brought to its end
    typedef enum logic [2:0] {
        END_DONE, END_SUM, END_TYPE, END_DIGIT, END_TRUNC
    } t_ending;

    // one row of the directed table
    typedef struct {
        t_in_word  word;
        bit        fixed;
        t_out_word want;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // predictor copy of the parser state, reset values
    t_ld_phase   ld_phase    = P_HUNT;
    logic        ld_low_next = 1'b0;
    logic [3:0]  ld_high     = '0;
    logic [7:0]  ld_left     = '0;
    logic [15:0] ld_addr     = '0;
    logic [7:0]  ld_rec      = '0;
    logic [7:0]  ld_sum      = '0;
    logic        ld_stopped  = 1'b0;

    // words the loader still owes us, oldest first
    t_out_word   due_q[$];
    t_dir_row    dir_tab[$];
    t_in_word    stim_q[$];
    t_in_word    rec_buf[$];

    bit          err_seen        = 1'b0;
    int unsigned send_idle_pct   = 0;
    int unsigned stall_pct       = 0;
    bit          stall_burst_req = 1'b0;
    int unsigned cycle_count     = 0;

    intel_hex_record_loader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic t_in_word word_of(input logic [7:0] ch, input logic eos);
        t_in_word w;
        w.char_code     = ch;
        w.end_of_stream = eos;
        return w;
    endfunction

    // ascii hex digit decode, returns 0 for anything else
    function automatic bit hex_value(input logic [7:0] ch, output logic [3:0] nib);
        logic [7:0] t;
        nib = 4'h0;
        if (ch >= CHR_ZERO && ch <= CHR_NINE) t = ch - CHR_ZERO;
        else if (ch >= CHR_UA && ch <= CHR_UF) t = ch - CHR_UA + 8'(DIGIT_TEN);
        else if (ch >= CHR_LA && ch <= CHR_LF) t = ch - CHR_LA + 8'(DIGIT_TEN);
        else return 1'b0;
        nib = t[3:0];
        return 1'b1;
    endfunction

    // letters come out in either case
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < DIGIT_TEN) return CHR_ZERO + 8'(nib);
        return (chance(50) ? CHR_UA : CHR_LA) + 8'(nib - DIGIT_TEN);
    endfunction

    // an error word also freezes the loader until reset
    function automatic t_out_word error_word(input logic [1:0] code);
        t_out_word r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        ld_stopped   = 1'b1;
        return r;
    endfunction

    // predictor: advance the parser by one accepted word
    task automatic parse_char(input t_in_word w, output bit got, output t_out_word res);
        logic [3:0] nib;
        logic [7:0] b;
        got = 1'b0;
        res = '0;
        if (ld_stopped) return;
        // between records only a colon matters, end of stream is harmless
        if (ld_phase == P_HUNT) begin
            if (!w.end_of_stream && w.char_code == CHR_COLON) begin
                ld_phase    = P_COUNT;
                ld_low_next = 1'b0;
                ld_high     = '0;
                ld_sum      = '0;
            end
            return;
        end
        if (w.end_of_stream) begin
            got = 1'b1;
            res = error_word(ERR_TRUNC);
            return;
        end
        if (!hex_value(w.char_code, nib)) begin
            got = 1'b1;
            res = error_word(ERR_DIGIT);
            return;
        end
        if (!ld_low_next) begin
            ld_high     = nib;
            ld_low_next = 1'b1;
            return;
        end
        ld_low_next = 1'b0;
        b           = {ld_high, nib};
        ld_sum      = ld_sum + b;
        case (ld_phase)
            P_COUNT: begin
                ld_left  = b;
                ld_phase = P_ADDR_HI;
            end
            P_ADDR_HI: begin
                ld_addr  = {b, 8'h00};
                ld_phase = P_ADDR_LO;
            end
            P_ADDR_LO: begin
                ld_addr[7:0] = b;
                ld_phase     = P_TYPE;
            end
            P_TYPE: begin
                // unknown type is flagged as soon as the byte is complete
                if (b != REC_DATA && b != REC_EOF) begin
                    got = 1'b1;
                    res = error_word(ERR_TYPE);
                end else begin
                    ld_rec   = b;
                    ld_phase = (ld_left == 0) ? P_CHECK : P_DATA;
                end
            end
            P_DATA: begin
                // eof data bytes only feed the checksum
                if (ld_rec == REC_DATA) begin
                    got           = 1'b1;
                    res.kind      = KIND_WRITE;
                    res.address   = ld_addr;
                    res.data_byte = b;
                    ld_addr       = ld_addr + 16'd1;
                end
                ld_left = ld_left - 8'd1;
                if (ld_left == 0) ld_phase = P_CHECK;
            end
            P_CHECK: begin
                if (ld_sum != 0) begin
                    got = 1'b1;
                    res = error_word(ERR_CHECKSUM);
                end else begin
                    ld_phase = P_HUNT;
                    if (ld_rec == REC_EOF) begin
                        got        = 1'b1;
                        res.kind   = KIND_DONE;
                        ld_stopped = 1'b1;
                    end
                end
            end
            default: ld_phase = P_HUNT;
        endcase
    endtask

    function automatic void dir_row(input logic [7:0] ch, input logic eos,
                                    input bit fixed, input t_out_word want);
        t_dir_row r;
        r.word  = word_of(ch, eos);
        r.fixed = fixed;
        r.want  = want;
        dir_tab.push_back(r);
    endfunction

    function automatic void dir_text(input string s);
        for (int k = 0; k < s.len(); k++) dir_row(s[k], 1'b0, 1'b0, '0);
    endfunction

    // full record into rec_buf, checksum optionally spoiled
    function automatic void build_record(input logic [7:0] rtype, input int unsigned cnt,
                                         input logic [15:0] addr, input bit bad_sum);
        logic [7:0] bytes[$];
        logic [7:0] sum;
        bytes = '{8'(cnt), addr[15:8], addr[7:0], rtype};
        for (int k = 0; k < cnt; k++) bytes.push_back(8'($urandom));
        sum = '0;
        foreach (bytes[k]) sum = sum + bytes[k];
        bytes.push_back((8'h00 - sum) ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00));
        rec_buf = {};
        rec_buf.push_back(word_of(CHR_COLON, 1'b0));
        foreach (bytes[k]) begin
            rec_buf.push_back(word_of(hex_char(bytes[k][7:4]), 1'b0));
            rec_buf.push_back(word_of(hex_char(bytes[k][3:0]), 1'b0));
        end
    endfunction

    function automatic logic [15:0] pick_addr();
        // some records start just below the top so the address wraps
        if (chance(12)) return 16'hFFF8 + 16'($urandom_range(7));
        return 16'($urandom);
    endfunction

    // offer one word, record what the loader should answer once it is taken
    task automatic send_word(input t_in_word w, input bit fixed, input t_out_word fixed_want);
        bit        got;
        t_out_word res;
        while (chance(send_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_char(w, got, res);
        if (fixed) due_q.push_back(fixed_want);
        else if (got) due_q.push_back(res);
        @(negedge i_clk);
    endtask

    // receiver side: random stalls plus one long hold-off on request
    initial begin : out_stall_ctl
        forever begin
            @(negedge i_clk);
            if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                for (int n = 0; n < BURST_CYCLES; n++) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_out_stall <= chance(stall_pct);
        end
    end

    function automatic void field_check(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
            err_seen = 1'b1;
        end
    endfunction

    // output checker, a word moves when valid is high and stall is low
    always @(posedge i_clk) begin : out_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %p", $time, o_out_word);
                err_seen = 1'b1;
            end else begin
                want = due_q.pop_front();
                field_check("kind", want.kind, o_out_word.kind);
                field_check("address", want.address, o_out_word.address);
                field_check("data_byte", want.data_byte, o_out_word.data_byte);
                field_check("error_code", want.error_code, o_out_word.error_code);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("intel_hex_record_loader_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_out_word   w_top;
        t_out_word   w_wrap;
        t_ending     ending;
        logic [7:0]  ch;
        logic [3:0]  nib;
        int unsigned cnt;
        int unsigned pos;
        int unsigned quarter;
        bit          big_done;

        w_top           = '0;
        w_top.kind      = KIND_WRITE;
        w_top.address   = 16'hFFFF;
        w_top.data_byte = 8'hAB;
        w_wrap          = '0;
        w_wrap.kind     = KIND_WRITE;
        w_wrap.data_byte = 8'hC0;

        // directed: junk and a harmless end of stream, then a two-byte record
        // at the top of memory that wraps, then an empty data record
        dir_row(8'hFF, 1'b0, 1'b0, '0);
        dir_row(CHR_COLON, 1'b1, 1'b0, '0);
        dir_text(":02FFff00A");
        dir_row("b", 1'b0, 1'b1, w_top);
        dir_text("c");
        dir_row("0", 1'b0, 1'b1, w_wrap);
        dir_text("95");
        dir_text(":0000000000");

        // random: well-formed data records with noise in between
        big_done = 1'b0;
        while (stim_q.size() < RANDOM_WORDS) begin
            repeat ($urandom_range(3)) begin
                if (chance(15)) begin
                    stim_q.push_back(word_of(8'($urandom), 1'b1));
                end else begin
                    do ch = 8'($urandom); while (ch == CHR_COLON);
                    stim_q.push_back(word_of(ch, 1'b0));
                end
            end
            // one record of the largest size, the rest short
            if (!big_done && stim_q.size() > 300) begin
                cnt      = 255;
                big_done = 1'b1;
            end else begin
                cnt = $urandom_range(16);
            end
            build_record(REC_DATA, cnt, pick_addr(), 1'b0);
            stim_q = {stim_q, rec_buf};
        end

        // the session ends once, by completion or by one of the errors
        ending = t_ending'($urandom_range(4));
        case (ending)
            END_DONE: build_record(REC_EOF, chance(50) ? $urandom_range(1, 8) : 0,
                                   pick_addr(), 1'b0);
            END_SUM: build_record(REC_DATA, $urandom_range(8), pick_addr(), 1'b1);
            END_TYPE: build_record(8'($urandom_range(2, 255)), $urandom_range(4),
                                   pick_addr(), 1'b0);
            END_DIGIT: begin
                build_record(REC_DATA, $urandom_range(4), pick_addr(), 1'b0);
                case ($urandom_range(2))
                    0: ch = CHR_COLON;
                    1: ch = CHR_SPACE;
                    default: do ch = 8'($urandom); while (hex_value(ch, nib));
                endcase
                pos          = $urandom_range(1, rec_buf.size() - 1);
                rec_buf[pos] = word_of(ch, 1'b0);
            end
            default: begin
                build_record(REC_DATA, $urandom_range(4), pick_addr(), 1'b0);
                pos          = $urandom_range(1, rec_buf.size() - 1);
                rec_buf[pos] = word_of(8'($urandom), 1'b1);
            end
        endcase
        stim_q = {stim_q, rec_buf};

        // after the end everything is ignored, a fresh record too
        build_record(REC_DATA, 2, pick_addr(), 1'b0);
        stim_q = {stim_q, rec_buf};
        repeat (20) stim_q.push_back(word_of(8'($urandom), 1'($urandom)));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) send_word(dir_tab[k].word, dir_tab[k].fixed, dir_tab[k].want);

        for (int idx = 0; idx < stim_q.size(); idx++) begin
            quarter = idx * 4 / stim_q.size();
            // idling phases: none, sender gaps, receiver stalls, both
            case (quarter)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 56; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            // long receiver hold-off while words keep coming, so the input backs up
            if (idx == 100) stall_burst_req = 1'b1;
            // sender pause until the loader has delivered everything owed
            if (idx == stim_q.size() / 2) begin
                i_in_valid <= 1'b0;
                wait (due_q.size() == 0);
                @(negedge i_clk);
            end
            send_word(stim_q[idx], 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        wait (due_q.size() == 0);
        // let the clock run on to catch any stray word
        repeat (8) @(posedge i_clk);
        if (!err_seen) begin
            $display("intel_hex_record_loader_tb passed");
        end else begin
            $display("intel_hex_record_loader_tb failed");
        end
        $finish;
    end

endmodule
